### hw/rtl/jeop_pkg.sv
// ----------------------------------------------------------------------------
// jeop_pkg: shared types and constants for the EXIF orientation parser
// Marker codes, TIFF constants and the result word carried between the
// parser core and the result queue.
// ----------------------------------------------------------------------------
package jeop_pkg;

  // JPEG marker bytes
  localparam logic [7:0] BYTE_FF   = 8'hFF;
  localparam logic [7:0] MARK_SOI  = 8'hD8;
  localparam logic [7:0] MARK_APP1 = 8'hE1;
  localparam logic [7:0] MARK_SOS  = 8'hDA;

  // TIFF header and IFD constants
  localparam logic [15:0] BOM_II      = 16'h4949;
  localparam logic [15:0] BOM_MM      = 16'h4D4D;
  localparam logic [15:0] TIFF_MAGIC  = 16'd42;
  localparam logic [15:0] TAG_ORIENT  = 16'h0112;
  localparam int          EntryBytes  = 12;
  localparam int          ExifIdBytes = 6;
  localparam int          TiffHdrBytes = 8;

  localparam logic [3:0] ORIENT_DEFAULT = 4'd1;
  localparam logic [3:0] ORIENT_MAX     = 4'd8;

  // One result word
  typedef struct packed {
    logic [3:0] orientation;
    logic       from_tag;
  } res_t;

  // Bytes of the "Exif\0\0" identifier
  function automatic logic [7:0] exif_id_byte(input logic [2:0] idx);
    logic [7:0] val;
    begin
      unique case (idx)
        3'd0:    val = 8'h45;
        3'd1:    val = 8'h78;
        3'd2:    val = 8'h69;
        3'd3:    val = 8'h66;
        default: val = 8'h00;
      endcase
      return val;
    end
  endfunction

endpackage

### hw/rtl/jeop_core.sv
// ----------------------------------------------------------------------------
// jeop_core: byte-wise JPEG segment walker and Exif IFD scanner
// Updates the parse state once per accepted word and flags a result word in
// the same cycle when the Exif segment or the file ends.
// ----------------------------------------------------------------------------
module jeop_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  output logic                res_valid,
  output jeop_pkg::res_t      res_word
);

  typedef enum logic [3:0] {
    PH_SOI0, PH_SOI1, PH_MARK_FF, PH_MARK_ID, PH_LEN_HI, PH_LEN_LO,
    PH_SKIP, PH_EXIF_ID, PH_TIFF, PH_DECIDED, PH_STOP
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  seg_marker, seg_marker_next;
  logic [15:0] seg_len, seg_len_next;
  logic [15:0] seg_pos, seg_pos_next;
  logic        little_endian, little_endian_next;
  logic [31:0] field_shift, field_shift_next;
  logic [31:0] dir_offset, dir_offset_next;
  logic [15:0] entries_left, entries_left_next;
  logic [15:0] entry_tag, entry_tag_next;
  logic [3:0]  found_value, found_value_next;
  logic        result_sent, result_sent_next;
  logic [3:0]  entry_pos, entry_pos_next;

  logic [31:0] fs_new;
  logic [15:0] rd16, hi16, body, pos_inc, tiff_pos, entries_dec;
  logic [31:0] rd32;
  logic [32:0] off_plus1;
  logic        seg_emit;

  // Byte-order aware views of the TIFF shift register
  assign fs_new    = {field_shift[23:0], data_byte};
  assign rd16      = little_endian ? {fs_new[7:0], fs_new[15:8]} : fs_new[15:0];
  assign hi16      = little_endian ? {fs_new[23:16], fs_new[31:24]} : fs_new[31:16];
  assign rd32      = little_endian ?
                     {fs_new[7:0], fs_new[15:8], fs_new[23:16], fs_new[31:24]} : fs_new;
  assign body      = seg_len - 16'd2;
  assign pos_inc   = seg_pos + 16'd1;
  assign tiff_pos  = seg_pos - 16'(jeop_pkg::ExifIdBytes);
  assign off_plus1 = {1'b0, dir_offset} + 33'd1;
  assign entries_dec = entries_left - 16'd1;

  // Next parse state for one word
  always_comb begin
    phase_next         = phase;
    seg_marker_next    = seg_marker;
    seg_len_next       = seg_len;
    seg_pos_next       = seg_pos;
    little_endian_next = little_endian;
    field_shift_next   = field_shift;
    dir_offset_next    = dir_offset;
    entries_left_next  = entries_left;
    entry_tag_next     = entry_tag;
    found_value_next   = found_value;
    result_sent_next   = result_sent;
    entry_pos_next     = entry_pos;
    seg_emit           = 1'b0;

    unique case (phase)
      PH_SOI0: begin
        phase_next = (data_byte == jeop_pkg::BYTE_FF) ? PH_SOI1 : PH_STOP;
      end
      PH_SOI1: begin
        phase_next = (data_byte == jeop_pkg::MARK_SOI) ? PH_MARK_FF : PH_STOP;
      end
      PH_MARK_FF: begin
        phase_next = (data_byte == jeop_pkg::BYTE_FF) ? PH_MARK_ID : PH_STOP;
      end
      PH_MARK_ID: begin
        seg_marker_next = data_byte;
        phase_next      = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        seg_len_next = {data_byte, 8'h00};
        phase_next   = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        seg_len_next = {seg_len[15:8], data_byte};
        seg_pos_next = 16'd0;
        if (seg_len_next < 16'd2 || seg_marker == jeop_pkg::MARK_SOS) begin
          phase_next = PH_STOP;
        end else if (seg_len_next == 16'd2) begin
          phase_next = PH_MARK_FF;
        end else if (seg_marker == jeop_pkg::MARK_APP1) begin
          phase_next = PH_EXIF_ID;
        end else begin
          phase_next = PH_SKIP;
        end
      end
      PH_SKIP, PH_EXIF_ID, PH_TIFF, PH_DECIDED: begin
        // Check the Exif identifier
        if (phase == PH_EXIF_ID) begin
          if (seg_pos >= 16'(jeop_pkg::ExifIdBytes) ||
              data_byte != jeop_pkg::exif_id_byte(seg_pos[2:0])) begin
            phase_next = PH_SKIP;
          end else if (seg_pos == 16'(jeop_pkg::ExifIdBytes - 1)) begin
            phase_next = (body > 16'(jeop_pkg::ExifIdBytes)) ? PH_TIFF : PH_SKIP;
          end
        end else if (phase == PH_TIFF && seg_pos >= 16'(jeop_pkg::ExifIdBytes)) begin
          field_shift_next = fs_new;
          if (tiff_pos < 16'(jeop_pkg::TiffHdrBytes)) begin
            // TIFF header: byte order, magic, IFD offset
            if (tiff_pos == 16'd1) begin
              if (fs_new[15:0] == jeop_pkg::BOM_II) begin
                little_endian_next = 1'b1;
              end else if (fs_new[15:0] == jeop_pkg::BOM_MM) begin
                little_endian_next = 1'b0;
              end else begin
                phase_next = PH_DECIDED;
              end
            end else if (tiff_pos == 16'd3) begin
              if (rd16 != jeop_pkg::TIFF_MAGIC) phase_next = PH_DECIDED;
            end else if (tiff_pos == 16'd7) begin
              dir_offset_next = rd32;
              if (rd32 < 32'(jeop_pkg::TiffHdrBytes)) phase_next = PH_DECIDED;
            end
          end else if ({16'h0000, tiff_pos} <= dir_offset) begin
            // still before the IFD
          end else if ({17'h00000, tiff_pos} == off_plus1) begin
            // IFD entry count
            entries_left_next = rd16;
            entry_pos_next    = 4'd0;
            if (rd16 == 16'd0) phase_next = PH_DECIDED;
          end else begin
            // Walk a 12-byte entry
            entry_pos_next = (entry_pos == 4'(jeop_pkg::EntryBytes - 1)) ?
                             4'd0 : entry_pos + 4'd1;
            if (entry_pos == 4'd1) begin
              entry_tag_next = rd16;
            end else if (entry_pos == 4'(jeop_pkg::EntryBytes - 1)) begin
              if (entry_tag == jeop_pkg::TAG_ORIENT) begin
                found_value_next = (hi16 >= 16'd1 && hi16 <= 16'(jeop_pkg::ORIENT_MAX)) ?
                                   hi16[3:0] : 4'd0;
                phase_next = PH_DECIDED;
              end else begin
                entries_left_next = entries_dec;
                if (entries_dec == 16'd0) phase_next = PH_DECIDED;
              end
            end
          end
        end
        // Advance through the body and close the segment
        seg_pos_next = pos_inc;
        if (pos_inc == body) begin
          if (phase_next == PH_TIFF || phase_next == PH_DECIDED) begin
            seg_emit         = 1'b1;
            result_sent_next = 1'b1;
            phase_next       = PH_STOP;
          end else begin
            phase_next = PH_MARK_FF;
          end
        end
      end
      default: begin
        phase_next = PH_STOP;
      end
    endcase
  end

  // Result word for this accepted byte
  always_comb begin
    res_valid = take && (seg_emit || (last_byte && !result_sent));
    if (seg_emit && found_value_next != 4'd0) begin
      res_word.orientation = found_value_next;
      res_word.from_tag    = 1'b1;
    end else begin
      res_word.orientation = jeop_pkg::ORIENT_DEFAULT;
      res_word.from_tag    = 1'b0;
    end
  end

  // Hold parse state; restart on reset or at the end of the file
  always_ff @(posedge clk) begin
    if (rst || (take && last_byte)) begin
      phase         <= PH_SOI0;
      seg_marker    <= 8'h00;
      seg_len       <= 16'h0000;
      seg_pos       <= 16'h0000;
      little_endian <= 1'b0;
      field_shift   <= 32'h0;
      dir_offset    <= 32'h0;
      entries_left  <= 16'h0000;
      entry_tag     <= 16'h0000;
      found_value   <= 4'd0;
      result_sent   <= 1'b0;
      entry_pos     <= 4'd0;
    end else if (take) begin
      phase         <= phase_next;
      seg_marker    <= seg_marker_next;
      seg_len       <= seg_len_next;
      seg_pos       <= seg_pos_next;
      little_endian <= little_endian_next;
      field_shift   <= field_shift_next;
      dir_offset    <= dir_offset_next;
      entries_left  <= entries_left_next;
      entry_tag     <= entry_tag_next;
      found_value   <= found_value_next;
      result_sent   <= result_sent_next;
      entry_pos     <= entry_pos_next;
    end
  end

endmodule

### hw/rtl/jeop_res_q.sv
// ----------------------------------------------------------------------------
// jeop_res_q: two-word result queue
// Output register plus skid slot, so the input side keeps taking words while
// a result waits for the consumer.
// ----------------------------------------------------------------------------
module jeop_res_q (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  jeop_pkg::res_t push_word,
  output logic           has_room,
  output logic           out_valid,
  input  logic           out_ready,
  output jeop_pkg::res_t head
);

  jeop_pkg::res_t tail;
  logic [1:0]     count;
  logic           pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign has_room  = (count != 2'd2);

  // Hold the fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  // Advance the payload slots
  always_ff @(posedge clk) begin
    if (pop) begin
      if (count == 2'd2) begin
        head <= tail;
        if (push) tail <= push_word;
      end else if (push) begin
        head <= push_word;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        head <= push_word;
      end else begin
        tail <= push_word;
      end
    end
  end

endmodule

### hw/rtl/jpeg_exif_orientation_parser.sv
// A result word is written into the result queue on the accepted byte that causes it
// (end of the Exif segment or the last byte of the file).
// Throughput: one byte per cycle while the result queue has room; the parse state updates once per byte.
// A two-word result queue keeps bytes flowing while one result is stalled;
// input stalls only while two result words wait.
// Reset (rst, synchronous) clears the parse state and empties the queue.
// ----------------------------------------------------------------------------
// jpeg_exif_orientation_parser: EXIF orientation from a JPEG byte stream
// Walks JPEG marker segments, parses the first Exif APP1 TIFF header and IFD,
// and reports the orientation tag value or the default once per file.
// ----------------------------------------------------------------------------
module jpeg_exif_orientation_parser (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] orientation,
  output logic       from_tag
);

  logic           take;
  logic           res_valid;
  jeop_pkg::res_t res_word;
  jeop_pkg::res_t head;

  assign take = in_valid && in_ready;

  // Parse one byte per accepted word
  jeop_core u_core (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .res_valid (res_valid),
    .res_word  (res_word)
  );

  // Queue result words toward the output
  jeop_res_q u_res_q (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_word (res_word),
    .has_room  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign orientation = head.orientation;
  assign from_tag    = head.from_tag;

endmodule

### hw/rtl/jeop_checker.sv
// ----------------------------------------------------------------------------
// jeop_checker: port-level checks for the orientation parser
// Watches the top-level ports and flags result words that break the rules.
// ----------------------------------------------------------------------------
module jeop_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] orientation,
  input logic       from_tag
);

  // A stalled result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // Orientation stays within the EXIF code range
  a_orient_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (orientation >= 4'd1 && orientation <= 4'd8))
    else $error("orientation out of range");

  // A defaulted result is always normal orientation
  a_default_one: assert property (@(posedge clk) disable iff (rst)
    out_valid && !from_tag |-> orientation == 4'd1)
    else $error("defaulted result is not orientation 1");

  // Queue is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered right after reset");

  // Input side is open right after reset
  a_reset_ready: assert property (@(posedge clk)
    rst |=> in_ready)
    else $error("input not ready right after reset");

endmodule

bind jpeg_exif_orientation_parser jeop_checker u_jeop_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .orientation (orientation),
  .from_tag    (from_tag)
);

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for the JPEG EXIF orientation parser
// Sends whole JPEG files one word at a time with random gaps on both sides.
// A model of the parser, kept in step with every accepted word, predicts
// each result, which is then checked field by field against the block.
// Directed files cover the marker walk, the TIFF header and the tag values;
// the random part sends mostly well-formed files, plus broken ones and noise.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // "Exif" 0 0, first byte in the top bits
  localparam logic [47:0] EXIF_SIG = 48'h457869660000;
  localparam int TotalWords = 900;
  localparam int RandFiles = 2;

  typedef enum logic [3:0] {
    ST_SOI_FF, ST_SOI_D8, ST_MARK_FF, ST_MARK_ID, ST_LEN_HI, ST_LEN_LO,
    ST_SKIP, ST_EXIF_ID, ST_TIFF, ST_DECIDED, ST_HALT
  } parse_state_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] data_byte = 8'h00;
  logic       last_byte = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [3:0] orientation;
  logic       from_tag;

  int   err_cnt = 0;
  int   n_sent = 0;
  int   hold_left = 0;
  bit   quiet = 1'b0;
  jeop_pkg::res_t orient_exp_q[$];
  logic [7:0] jpg[$];

  // Parser model state
  parse_state_t p_phase;
  logic [7:0]   p_marker;
  logic [15:0]  p_len;
  logic [15:0]  p_pos;
  logic         p_le;
  logic [31:0]  p_shift;
  logic [31:0]  p_ifd;
  logic [15:0]  p_left;
  logic [15:0]  p_tag;
  logic [15:0]  p_found;
  logic         p_sent;

  jpeg_exif_orientation_parser dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .last_byte   (last_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .orientation (orientation),
    .from_tag    (from_tag)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Parser model
  // --------------------------------------------------------------------------
  function automatic void clear_parse();
    p_phase  = ST_SOI_FF;
    p_marker = '0;
    p_len    = '0;
    p_pos    = '0;
    p_le     = 1'b0;
    p_shift  = '0;
    p_ifd    = '0;
    p_left   = '0;
    p_tag    = '0;
    p_found  = '0;
    p_sent   = 1'b0;
  endfunction

  function automatic logic [15:0] tiff16(input logic [15:0] v);
    return p_le ? {v[7:0], v[15:8]} : v;
  endfunction

  // One TIFF byte at offset t from the TIFF header
  function automatic void tiff_advance(input logic [7:0] b, input logic [15:0] t);
    longint unsigned tl;
    longint unsigned off;
    longint unsigned k;
    logic [15:0]     val;
    tl = t;
    off = p_ifd;
    p_shift = {p_shift[23:0], b};
    if (tl < jeop_pkg::TiffHdrBytes) begin
      if (tl == 1) begin
        if (p_shift[15:0] == jeop_pkg::BOM_II) p_le = 1'b1;
        else if (p_shift[15:0] == jeop_pkg::BOM_MM) p_le = 1'b0;
        else p_phase = ST_DECIDED;
      end else if (tl == 3) begin
        if (tiff16(p_shift[15:0]) != jeop_pkg::TIFF_MAGIC) p_phase = ST_DECIDED;
      end else if (tl == 7) begin
        p_ifd = p_le ? {p_shift[7:0], p_shift[15:8], p_shift[23:16], p_shift[31:24]}
                     : p_shift;
        if (p_ifd < jeop_pkg::TiffHdrBytes) p_phase = ST_DECIDED;
      end
    end else if (tl == off + 1) begin
      p_left = tiff16(p_shift[15:0]);
      if (p_left == 0) p_phase = ST_DECIDED;
    end else if (tl > off + 1) begin
      k = (tl - off - 2) % jeop_pkg::EntryBytes;
      if (k == 1) begin
        p_tag = tiff16(p_shift[15:0]);
      end else if (k == jeop_pkg::EntryBytes - 1) begin
        if (p_tag == jeop_pkg::TAG_ORIENT) begin
          val = tiff16(p_shift[31:16]);
          p_found = (val >= 1 && val <= jeop_pkg::ORIENT_MAX) ? val : 16'd0;
          p_phase = ST_DECIDED;
        end else begin
          p_left = p_left - 16'd1;
          if (p_left == 0) p_phase = ST_DECIDED;
        end
      end
    end
  endfunction

  // Advance the model by one word; return 1 when it yields a result
  function automatic bit predict_orientation(input logic [7:0] b, input logic last,
                                             output jeop_pkg::res_t r);
    bit          hit;
    logic [15:0] body;
    logic [15:0] p;
    logic [47:0] sh;
    hit = 1'b0;
    r = '0;
    case (p_phase)
      ST_SOI_FF: begin
        if (b == jeop_pkg::BYTE_FF) p_phase = ST_SOI_D8;
        else p_phase = ST_HALT;
      end
      ST_SOI_D8: begin
        if (b == jeop_pkg::MARK_SOI) p_phase = ST_MARK_FF;
        else p_phase = ST_HALT;
      end
      ST_MARK_FF: begin
        if (b == jeop_pkg::BYTE_FF) p_phase = ST_MARK_ID;
        else p_phase = ST_HALT;
      end
      ST_MARK_ID: begin
        p_marker = b;
        p_phase = ST_LEN_HI;
      end
      ST_LEN_HI: begin
        p_len = {b, 8'h00};
        p_phase = ST_LEN_LO;
      end
      ST_LEN_LO: begin
        p_len = {p_len[15:8], b};
        p_pos = '0;
        if (p_len < 2 || p_marker == jeop_pkg::MARK_SOS) p_phase = ST_HALT;
        else if (p_len == 2) p_phase = ST_MARK_FF;
        else if (p_marker == jeop_pkg::MARK_APP1) p_phase = ST_EXIF_ID;
        else p_phase = ST_SKIP;
      end
      ST_SKIP, ST_EXIF_ID, ST_TIFF, ST_DECIDED: begin
        body = p_len - 16'd2;
        p = p_pos;
        if (p_phase == ST_EXIF_ID) begin
          if (p >= jeop_pkg::ExifIdBytes) begin
            p_phase = ST_SKIP;
          end else begin
            sh = EXIF_SIG << (8 * p);
            if (b != sh[47:40]) p_phase = ST_SKIP;
            else if (p == jeop_pkg::ExifIdBytes - 1) begin
              if (body > jeop_pkg::ExifIdBytes) p_phase = ST_TIFF;
              else p_phase = ST_SKIP;
            end
          end
        end else if (p_phase == ST_TIFF && p >= jeop_pkg::ExifIdBytes) begin
          tiff_advance(b, 16'(p - jeop_pkg::ExifIdBytes));
        end
        p_pos = p + 16'd1;
        if (p_pos == body) begin
          if (p_phase == ST_TIFF || p_phase == ST_DECIDED) begin
            hit = 1'b1;
            r.orientation = (p_found != 0) ? p_found[3:0] : jeop_pkg::ORIENT_DEFAULT;
            r.from_tag = (p_found != 0);
            p_sent = 1'b1;
            p_phase = ST_HALT;
          end else begin
            p_phase = ST_MARK_FF;
          end
        end
      end
      default: p_phase = ST_HALT;
    endcase
    // end of file: default result if none given, then start over
    if (last) begin
      if (!p_sent && !hit) begin
        hit = 1'b1;
        r.orientation = jeop_pkg::ORIENT_DEFAULT;
        r.from_tag = 1'b0;
      end
      clear_parse();
    end
    return hit;
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard: check results first, then predict from the accepted word
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    jeop_pkg::res_t want;
    jeop_pkg::res_t got;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (orient_exp_q.size() == 0) begin
          $error("orientation: unexpected result %0d (from_tag %0d)", orientation, from_tag);
          err_cnt++;
        end else begin
          want = orient_exp_q.pop_front();
          if (orientation !== want.orientation) begin
            $error("orientation: expected %0d, got %0d", want.orientation, orientation);
            err_cnt++;
          end
          if (from_tag !== want.from_tag) begin
            $error("from_tag: expected %0d, got %0d", want.from_tag, from_tag);
            err_cnt++;
          end
        end
      end
      if (in_valid && in_ready) begin
        n_sent++;
        if (predict_orientation(data_byte, last_byte, got)) orient_exp_q.push_back(got);
      end
    end
  end

  // Mostly short stalls, a few long ones
  function automatic int gap_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Result side: random back-pressure
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!quiet && $urandom_range(0, 99) < 20) begin
      out_ready <= 1'b0;
      hold_left <= gap_len() - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Word sender and file builders
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = (!quiet && $urandom_range(0, 99) < 25) ? gap_len() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_file();
    for (int i = 0; i < jpg.size(); i++) send_byte(jpg[i], i == jpg.size() - 1);
  endtask

  function automatic void put(input logic [7:0] b);
    jpg.push_back(b);
  endfunction

  function automatic void put16(input logic [15:0] v, input bit le);
    if (le) begin
      put(v[7:0]);
      put(v[15:8]);
    end else begin
      put(v[15:8]);
      put(v[7:0]);
    end
  endfunction

  function automatic void put32(input logic [31:0] v, input bit le);
    if (le) begin
      put16(v[15:0], 1'b1);
      put16(v[31:16], 1'b1);
    end else begin
      put16(v[31:16], 1'b0);
      put16(v[15:0], 1'b0);
    end
  endfunction

  function automatic void put_rand(input int n);
    repeat (n) put(8'($urandom_range(0, 255)));
  endfunction

  function automatic void put_sig();
    logic [47:0] sh;
    sh = EXIF_SIG;
    repeat (jeop_pkg::ExifIdBytes) begin
      put(sh[47:40]);
      sh = sh << 8;
    end
  endfunction

  function automatic void begin_file();
    jpg.delete();
    put(jeop_pkg::BYTE_FF);
    put(jeop_pkg::MARK_SOI);
  endfunction

  function automatic void add_segment(input logic [7:0] mark, input int body);
    put(jeop_pkg::BYTE_FF);
    put(mark);
    put16(16'(body + 2), 1'b0);
    put_rand(body);
  endfunction

  function automatic void add_scan(input int n);
    put(jeop_pkg::BYTE_FF);
    put(jeop_pkg::MARK_SOS);
    put16(16'd4, 1'b0);
    put_rand(2 + n);
  endfunction

  // Exif APP1 segment; tag_at selects the orientation entry (none if out of
  // range), cut shortens the length field below the bytes written
  function automatic void add_exif(input logic [15:0] bom, input logic [15:0] magic,
                                   input bit le, input logic [31:0] ifd,
                                   input logic [15:0] ent_cnt, input int n_ent,
                                   input int tag_at, input logic [15:0] val,
                                   input int tail, input int cut);
    int          at;
    logic [15:0] len;
    logic [15:0] tg;
    logic [15:0] tv;
    put(jeop_pkg::BYTE_FF);
    put(jeop_pkg::MARK_APP1);
    at = jpg.size();
    put(8'h00);
    put(8'h00);
    put_sig();
    put16(bom, 1'b0);
    put16(magic, le);
    put32(ifd, le);
    if (ifd >= jeop_pkg::TiffHdrBytes && ifd < 40) begin
      put_rand(int'(ifd) - jeop_pkg::TiffHdrBytes);
    end
    put16(ent_cnt, le);
    for (int i = 0; i < n_ent; i++) begin
      tg = 16'($urandom_range(0, 65535));
      if (tg == jeop_pkg::TAG_ORIENT) tg = 16'h0100;
      tv = 16'($urandom_range(0, 65535));
      put16((i == tag_at) ? jeop_pkg::TAG_ORIENT : tg, le);
      put16(16'd3, le);
      put32(32'd1, le);
      put16((i == tag_at) ? val : tv, le);
      put_rand(2);
    end
    put_rand(tail);
    len = 16'(jpg.size() - at - cut);
    jpg[at] = len[15:8];
    jpg[at + 1] = len[7:0];
  endfunction

  function automatic void add_good_exif(input bit le, input logic [15:0] val);
    add_exif(le ? jeop_pkg::BOM_II : jeop_pkg::BOM_MM, jeop_pkg::TIFF_MAGIC, le, 32'd8,
             16'd1, 1, 0, val, 0, 0);
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_start_of_image();
    quiet = 1'b1;
    // one-word file that is not a JPEG
    jpg.delete();
    put(8'h00);
    send_file();
    // FF without D8
    jpg.delete();
    put(jeop_pkg::BYTE_FF);
    put(8'h00);
    put_rand(3);
    send_file();
    // bare SOI
    begin_file();
    send_file();
    quiet = 1'b0;
  endtask

  task automatic test_marker_walk();
    // segment start that is not FF
    begin_file();
    put(8'h12);
    put_rand(3);
    send_file();
    // length 1 stops before a good Exif
    begin_file();
    put(jeop_pkg::BYTE_FF);
    put(8'hE0);
    put16(16'd1, 1'b0);
    add_good_exif(1'b1, 16'd6);
    send_file();
    // length 0
    begin_file();
    put(jeop_pkg::BYTE_FF);
    put(8'hE0);
    put16(16'd0, 1'b0);
    put_rand(2);
    send_file();
    // empty segment, fill marker FF FF with a length, then Exif and scan
    begin_file();
    add_segment(8'hE0, 0);
    add_segment(jeop_pkg::BYTE_FF, 3);
    add_good_exif(1'b1, 16'd3);
    add_scan(2);
    send_file();
    // SOS before Exif
    begin_file();
    add_scan(4);
    add_good_exif(1'b0, 16'd5);
    send_file();
  endtask

  task automatic test_orientation_values();
    begin_file();
    add_good_exif(1'b1, 16'd1);
    add_scan(3);
    send_file();
    begin_file();
    add_good_exif(1'b0, 16'd8);
    add_scan(1);
    send_file();
    // out-of-range values fall back to the default
    begin_file();
    add_good_exif(1'b1, 16'd0);
    send_file();
    begin_file();
    add_good_exif(1'b0, 16'd9);
    send_file();
    begin_file();
    add_good_exif(1'b1, 16'hFFFF);
    send_file();
    // tag behind two other entries
    begin_file();
    add_exif(jeop_pkg::BOM_MM, jeop_pkg::TIFF_MAGIC, 1'b0, 32'd10, 16'd3, 3, 2, 16'd5,
             2, 0);
    send_file();
    // entries run out without the tag
    begin_file();
    add_exif(jeop_pkg::BOM_II, jeop_pkg::TIFF_MAGIC, 1'b1, 32'd8, 16'd2, 2, 5, 16'd4,
             3, 0);
    send_file();
    // zero entries
    begin_file();
    add_exif(jeop_pkg::BOM_II, jeop_pkg::TIFF_MAGIC, 1'b1, 32'd8, 16'd0, 1, 0, 16'd4,
             0, 0);
    send_file();
  endtask

  task automatic test_tiff_header();
    quiet = 1'b1;
    begin_file();
    add_exif(16'h4D49, jeop_pkg::TIFF_MAGIC, 1'b0, 32'd8, 16'd1, 1, 0, 16'd6, 0, 0);
    send_file();
    begin_file();
    add_exif(jeop_pkg::BOM_II, 16'd43, 1'b1, 32'd8, 16'd1, 1, 0, 16'd6, 0, 0);
    send_file();
    quiet = 1'b0;
    begin_file();
    add_exif(jeop_pkg::BOM_II, jeop_pkg::TIFF_MAGIC, 1'b1, 32'd7, 16'd1, 1, 0, 16'd6,
             0, 0);
    send_file();
    begin_file();
    add_exif(jeop_pkg::BOM_MM, jeop_pkg::TIFF_MAGIC, 1'b0, 32'd0, 16'd1, 1, 0, 16'd6,
             0, 0);
    send_file();
    // IFD beyond the segment
    begin_file();
    add_exif(jeop_pkg::BOM_MM, jeop_pkg::TIFF_MAGIC, 1'b0, 32'd200, 16'd1, 1, 0, 16'd6,
             0, 0);
    send_file();
    begin_file();
    add_exif(jeop_pkg::BOM_II, jeop_pkg::TIFF_MAGIC, 1'b1, 32'hFFFF_FFFF, 16'd1, 1, 0,
             16'd6, 0, 0);
    send_file();
    // segment ends inside the entry holding the tag
    begin_file();
    add_exif(jeop_pkg::BOM_II, jeop_pkg::TIFF_MAGIC, 1'b1, 32'd8, 16'd3, 3, 2, 16'd7,
             0, 6);
    add_scan(2);
    send_file();
  endtask

  task automatic test_exif_segments();
    // APP1 without the Exif header is skipped
    begin_file();
    add_segment(jeop_pkg::MARK_APP1, 8);
    add_good_exif(1'b0, 16'd2);
    send_file();
    // Exif header with no TIFF data
    begin_file();
    put(jeop_pkg::BYTE_FF);
    put(jeop_pkg::MARK_APP1);
    put16(16'd8, 1'b0);
    put_sig();
    add_good_exif(1'b1, 16'd7);
    send_file();
    // Exif header wrong in its last byte
    begin_file();
    put(jeop_pkg::BYTE_FF);
    put(jeop_pkg::MARK_APP1);
    put16(16'd12, 1'b0);
    put_sig();
    jpg[jpg.size() - 1] = 8'h01;
    put_rand(4);
    add_good_exif(1'b1, 16'd2);
    send_file();
    // stream ends inside the Exif segment after the tag was seen
    begin_file();
    add_exif(jeop_pkg::BOM_II, jeop_pkg::TIFF_MAGIC, 1'b1, 32'd8, 16'd1, 1, 0, 16'd4,
             4, 0);
    jpg.delete(jpg.size() - 1);
    jpg.delete(jpg.size() - 1);
    send_file();
    // only the first Exif counts
    begin_file();
    add_good_exif(1'b0, 16'd2);
    add_good_exif(1'b1, 16'd5);
    send_file();
  endtask

  task automatic build_random_jpeg();
    logic [7:0]  mark;
    logic [15:0] bom;
    logic [15:0] magic;
    logic [31:0] ifd;
    logic [15:0] ent_cnt;
    logic [15:0] val;
    int          n_ent;
    int          r;
    bit          le;
    begin_file();
    repeat ($urandom_range(0, 2)) begin
      mark = 8'($urandom_range(8'hC0, 8'hFE));
      if (mark == jeop_pkg::MARK_SOS) mark = 8'hDB;
      if ($urandom_range(0, 9) == 0) mark = jeop_pkg::BYTE_FF;
      add_segment(mark, $urandom_range(0, 10));
    end
    if ($urandom_range(0, 99) < 85) begin
      le = 1'($urandom_range(0, 1));
      bom = le ? jeop_pkg::BOM_II : jeop_pkg::BOM_MM;
      if ($urandom_range(0, 19) == 0) bom = 16'($urandom_range(0, 65535));
      magic = jeop_pkg::TIFF_MAGIC;
      if ($urandom_range(0, 19) == 0) magic = 16'($urandom_range(0, 65535));
      r = $urandom_range(0, 99);
      if (r < 80) ifd = 32'(8 + $urandom_range(0, 8));
      else if (r < 90) ifd = 32'($urandom_range(0, 7));
      else if (r < 95) ifd = 32'($urandom_range(8, 200));
      else ifd = $urandom;
      n_ent = $urandom_range(0, 4);
      r = $urandom_range(0, 99);
      if (r < 80) ent_cnt = 16'(n_ent);
      else if (r < 95) ent_cnt = 16'($urandom_range(0, 6));
      else ent_cnt = 16'($urandom_range(0, 65535));
      val = 16'(($urandom_range(0, 3) != 0) ? $urandom_range(1, 8)
                                             : $urandom_range(0, 65535));
      add_exif(bom, magic, le, ifd, ent_cnt, n_ent, $urandom_range(0, n_ent), val,
               $urandom_range(0, 4),
               ($urandom_range(0, 99) < 85) ? 0 : $urandom_range(1, 24));
    end
    if ($urandom_range(0, 99) < 80) add_scan($urandom_range(0, 8));
  endtask

  task automatic test_random_streams();
    int files;
    int r;
    int n;
    files = 0;
    while (n_sent < TotalWords || files < RandFiles) begin
      quiet = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 70) begin
        build_random_jpeg();
      end else if (r < 85) begin
        // break a well-formed file: corrupt one word or cut it short
        build_random_jpeg();
        if ($urandom_range(0, 1)) begin
          jpg[$urandom_range(0, jpg.size() - 1)] = 8'($urandom_range(0, 255));
        end else begin
          n = $urandom_range(1, jpg.size());
          while (jpg.size() > n) jpg.delete(jpg.size() - 1);
        end
      end else begin
        jpg.delete();
        if ($urandom_range(0, 1)) begin
          put(jeop_pkg::BYTE_FF);
          put(jeop_pkg::MARK_SOI);
        end
        put_rand($urandom_range(1, 16));
      end
      send_file();
      files++;
    end
    quiet = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    clear_parse();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_start_of_image();
    test_marker_walk();
    test_orientation_values();
    test_tiff_header();
    test_exif_segments();
    test_random_streams();
    in_valid <= 1'b0;
    // drain outstanding results
    for (int i = 0; i < 20000 && orient_exp_q.size() != 0; i++) @(posedge clk);
    if (orient_exp_q.size() != 0) begin
      $error("orientation: %0d results never arrived", orient_exp_q.size());
      err_cnt++;
    end
    repeat (10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/jeop_pkg.sv
hw/rtl/jeop_core.sv
hw/rtl/jeop_res_q.sv
hw/rtl/jpeg_exif_orientation_parser.sv
hw/rtl/jeop_checker.sv
dv/tb.sv
